### src/seven_segment_scan_and_key_matrix_defines.svh
// Assertion macros shared by the checker files.
`ifndef SEVEN_SEGMENT_SCAN_AND_KEY_MATRIX_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_AND_KEY_MATRIX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSKM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sskm check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSKM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sskm check failed");

`endif

### src/sskm_pkg.sv
// Types, codes and the character table of the display and key scan block.
package sskm_pkg;

	localparam int SCAN_W  = 3;
	localparam int SEG_W   = 8;
	localparam int PINS    = 4;
	localparam int TICK_W  = 9;
	localparam int HOLD_W  = 8;

	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 9'd492;
	localparam logic [HOLD_W-1:0] HOLD_REPEAT_RST = 8'd50;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_ASSIGN = 3'd1,
		OP_OR     = 3'd2,
		OP_AND    = 3'd3,
		OP_CHAR   = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_SWAP   = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	typedef enum logic {
		REG_TICK_PERIOD_MAX = 1'b0,
		REG_HOLD_REPEAT     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t              opcode;
		logic             key_sense;
		logic [2:0]       digit;
		logic [SEG_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic second;
		logic half;
		logic quarter;
		logic slow;
		logic fast;
	} tick_status_t;

	typedef struct packed {
		logic [SCAN_W-1:0] pos;
		logic              frame_end;
	} scan_t;

	localparam int GLYPH_LAST = 38;

	localparam logic [SEG_W-1:0] GLYPHS [0:GLYPH_LAST] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h04, 8'h1E,
		8'h36, 8'h38, 8'h53, 8'h54, 8'h5C, 8'h73, 8'h53, 8'h50, 8'h6D, 8'h78,
		8'h3E, 8'h1C, 8'h53, 8'h53, 8'h6E, 8'h53, 8'h00, 8'h40, 8'h53
	};

	// Codes past the table end show the last entry.
	function automatic logic [SEG_W-1:0] glyph(input logic [SEG_W-1:0] code);
		logic [5:0] idx;
		if (code > SEG_W'(GLYPH_LAST)) begin
			idx = 6'(GLYPH_LAST);
		end else begin
			idx = code[5:0];
		end
		return GLYPHS[idx];
	endfunction

endpackage

### src/sskm_ticker.sv
// Tick counter with second, half and quarter pulses and two toggles.
module sskm_ticker import sskm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [TICK_W-1:0] period_max,
	output tick_status_t      status
);

	logic [TICK_W-1:0] count_q;
	logic [TICK_W-1:0] count_nxt;
	logic              slow_q;
	logic              fast_q;
	logic              wrap;
	logic              at_half;
	logic              at_quarter;

	always_comb begin
		wrap       = !(count_q < period_max);
		count_nxt  = wrap ? '0 : count_q + 1'b1;
		at_half    = (count_nxt == 9'd0) || (count_nxt == 9'd250) || (count_nxt == 9'd500);
		at_quarter = at_half || (count_nxt == 9'd125) || (count_nxt == 9'd375);
	end

	always_comb begin
		status.second  = fire && wrap;
		status.half    = fire && at_half;
		status.quarter = fire && at_quarter;
		status.slow    = slow_q ^ (fire && at_half);
		status.fast    = fast_q ^ (fire && at_quarter);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			slow_q  <= 1'b0;
			fast_q  <= 1'b0;
		end else if (fire) begin
			count_q <= count_nxt;
			slow_q  <= status.slow;
			fast_q  <= status.fast;
		end
	end

endmodule

### src/sskm_scan.sv
// Digit scan position, key sampling, press detection and hold repeat.
module sskm_scan import sskm_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire_tick,
	input  logic              fire_read,
	input  logic              key_sense,
	input  logic [HOLD_W-1:0] hold_reload,
	output scan_t             scan,
	output logic [PINS-1:0]   digit_drive_nxt,
	output logic [PINS-1:0]   press_rep,
	output logic [PINS-1:0]   held_rep
);

	localparam logic [SCAN_W-1:0] LAST_POS = SCAN_W'(DIGITS - 1);

	logic [SCAN_W-1:0] pos_q;
	logic [SCAN_W-1:0] pos_nxt;
	logic [PINS-1:0]   live_q;
	logic [PINS-1:0]   live_nxt;
	logic [PINS-1:0]   prev_q;
	logic [PINS-1:0]   prev_nxt;
	logic [PINS-1:0]   press_q;
	logic [PINS-1:0]   held_q;
	logic [HOLD_W-1:0] hold_q;
	logic [HOLD_W-1:0] hold_nxt;
	logic [HOLD_W-1:0] hold_dec;
	logic              frame_end;

	always_comb begin
		live_nxt = live_q;
		for (int j = 0; j < PINS; j++) begin
			digit_drive_nxt[j] = (pos_q != SCAN_W'(j));
			if (fire_tick && (pos_q == SCAN_W'(j))) begin
				live_nxt[j] = !key_sense;
			end
		end
		frame_end = fire_tick && (pos_q == LAST_POS);
		if (!fire_tick) begin
			pos_nxt = pos_q;
		end else if (pos_q == LAST_POS) begin
			pos_nxt = '0;
		end else begin
			pos_nxt = pos_q + 1'b1;
		end
	end

	always_comb begin
		press_rep = press_q;
		held_rep  = held_q;
		prev_nxt  = prev_q;
		hold_nxt  = hold_q;
		hold_dec  = hold_q - 1'b1;
		if (frame_end) begin
			press_rep = press_q | (live_nxt & ~prev_q);
			prev_nxt  = live_nxt;
			if (live_nxt != '0) begin
				if (hold_dec == '0) begin
					hold_nxt = hold_reload;
					held_rep = held_q | live_nxt;
				end else begin
					hold_nxt = hold_dec;
				end
			end else begin
				hold_nxt = hold_reload;
			end
		end
	end

	assign scan.pos       = pos_q;
	assign scan.frame_end = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			live_q  <= '0;
			prev_q  <= '0;
			hold_q  <= '0;
			press_q <= '0;
			held_q  <= '0;
		end else begin
			pos_q   <= pos_nxt;
			live_q  <= live_nxt;
			prev_q  <= prev_nxt;
			hold_q  <= hold_nxt;
			press_q <= fire_read ? '0 : press_rep;
			held_q  <= fire_read ? '0 : held_rep;
		end
	end

endmodule

### src/sskm_frame.sv
// Double-buffered digit bytes: back-buffer writes, front read-out and swap.
module sskm_frame import sskm_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  item_t            item,
	input  scan_t            scan,
	output logic [SEG_W-1:0] seg_nxt,
	output logic             swap_nxt
);

	logic [SEG_W-1:0] buf0_q [DIGITS];
	logic [SEG_W-1:0] buf1_q [DIGITS];
	logic [SEG_W-1:0] lane_data [DIGITS];
	logic [DIGITS-1:0] lane_we;
	logic             front_q;
	logic             swap_q;
	logic             front_nxt;
	logic [SEG_W-1:0] front_byte;
	logic [SEG_W-1:0] back_byte;

	// Front byte at the scan position, pins are active low.
	always_comb begin
		front_byte = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (scan.pos == SCAN_W'(d)) begin
				front_byte = front_q ? buf0_q[d] : buf1_q[d];
			end
		end
		seg_nxt = ~front_byte;
	end

	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			back_byte    = front_q ? buf1_q[d] : buf0_q[d];
			lane_we[d]   = 1'b0;
			lane_data[d] = back_byte;
			case (item.opcode)
				OP_ASSIGN: begin
					lane_we[d]   = (item.digit == 3'(d));
					lane_data[d] = item.value;
				end
				OP_OR: begin
					lane_we[d]   = (item.digit == 3'(d));
					lane_data[d] = back_byte | item.value;
				end
				OP_AND: begin
					lane_we[d]   = (item.digit == 3'(d));
					lane_data[d] = back_byte & item.value;
				end
				OP_CHAR: begin
					lane_we[d]   = (item.digit == 3'(d));
					lane_data[d] = glyph(item.value);
				end
				OP_CLEAR: begin
					lane_we[d]   = 1'b1;
					lane_data[d] = '0;
				end
				default: begin
					lane_we[d]   = 1'b0;
				end
			endcase
		end
	end

	// Swap is taken at frame end, after the last digit has been read out.
	always_comb begin
		swap_nxt  = swap_q;
		front_nxt = front_q;
		if (fire && (item.opcode == OP_SWAP)) begin
			swap_nxt = 1'b1;
		end else if (scan.frame_end && swap_q) begin
			swap_nxt  = 1'b0;
			front_nxt = !front_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= 1'b1;
			swap_q  <= 1'b0;
			for (int d = 0; d < DIGITS; d++) begin
				buf0_q[d] <= '0;
				buf1_q[d] <= '0;
			end
		end else begin
			front_q <= front_nxt;
			swap_q  <= swap_nxt;
			for (int d = 0; d < DIGITS; d++) begin
				if (fire && lane_we[d]) begin
					if (front_q) begin
						buf1_q[d] <= lane_data[d];
					end else begin
						buf0_q[d] <= lane_data[d];
					end
				end
			end
		end
	end

endmodule

### src/seven_segment_scan_and_key_matrix.sv
// Top level of the multiplexed seven-segment display driver with key scan.
// One transaction in gives exactly one transaction out, and a new transaction
// is taken every cycle while the output side keeps up. An accepted transaction
// goes into the input register, then through one pass of logic into the
// result register, from which the output handshake is made.
// A stalled result is held in the result register while the input register
// still takes one more transaction, so the two sides are parted by a stage.
// A tick transaction drives the next digit of the front buffer (segment pins
// active low, digit select active low one-hot, only the first four positions
// have pins and key bits), samples the key line into that digit's bit and
// advances the tick counter, which pulses tick_second on wrap, tick_half at
// counts 0, 250 and 500 and tick_quarter at every multiple of 125. After the
// last digit of a frame, new presses and hold repeats are latched and any
// requested buffer swap is done. Writes touch only the back buffer; a digit
// at or beyond DIGITS is ignored. A key read reports the flags as they stood
// and then clears them. Configuration writes take effect at once and must
// only be made while no transaction is in flight.
module seven_segment_scan_and_key_matrix import sskm_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [TICK_W-1:0] cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        opcode,
	input  logic              key_sense,
	input  logic [2:0]        digit,
	input  logic [SEG_W-1:0]  value,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SEG_W-1:0]  segment_drive,
	output logic [PINS-1:0]   digit_drive,
	output logic              tick_second,
	output logic              tick_half,
	output logic              tick_quarter,
	output logic              toggle_slow,
	output logic              toggle_fast,
	output logic [PINS-1:0]   key_pressed,
	output logic [PINS-1:0]   key_held,
	output logic              swap_pending
);

	// configuration registers
	logic [TICK_W-1:0] tick_period_max_q;
	logic [HOLD_W-1:0] hold_repeat_frames_q;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic             valid_s2;
	logic [SEG_W-1:0] seg_s2;
	logic [PINS-1:0]  dig_s2;
	tick_status_t     tick_s2;
	logic [PINS-1:0]  press_s2;
	logic [PINS-1:0]  held_s2;
	logic             swap_s2;

	logic             go;
	logic             fire_tick;
	logic             fire_read;
	tick_status_t     tick_nxt;
	scan_t            scan;
	logic [PINS-1:0]  digit_drive_nxt;
	logic [PINS-1:0]  press_rep;
	logic [PINS-1:0]  held_rep;
	logic [SEG_W-1:0] seg_nxt;
	logic             swap_nxt;

	// the item in stage 1 moves on when the result register is free or drains
	assign go        = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || go;
	assign fire_tick = go && (item_s1.opcode == OP_TICK);
	assign fire_read = go && (item_s1.opcode == OP_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_max_q    <= TICK_PERIOD_RST;
			hold_repeat_frames_q <= HOLD_REPEAT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TICK_PERIOD_MAX: tick_period_max_q    <= cfg_data;
				REG_HOLD_REPEAT:     hold_repeat_frames_q <= cfg_data[HOLD_W-1:0];
				default:             tick_period_max_q    <= tick_period_max_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode    <= op_t'(opcode);
			item_s1.key_sense <= key_sense;
			item_s1.digit     <= digit;
			item_s1.value     <= value;
		end
	end

	sskm_ticker u_ticker (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_tick),
		.period_max (tick_period_max_q),
		.status     (tick_nxt)
	);

	sskm_scan #(
		.DIGITS (DIGITS)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire_tick       (fire_tick),
		.fire_read       (fire_read),
		.key_sense       (item_s1.key_sense),
		.hold_reload     (hold_repeat_frames_q),
		.scan            (scan),
		.digit_drive_nxt (digit_drive_nxt),
		.press_rep       (press_rep),
		.held_rep        (held_rep)
	);

	sskm_frame #(
		.DIGITS (DIGITS)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (go),
		.item     (item_s1),
		.scan     (scan),
		.seg_nxt  (seg_nxt),
		.swap_nxt (swap_nxt)
	);

	// the pins hold between ticks, so these fields carry reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			seg_s2   <= '1;
			dig_s2   <= '1;
		end else begin
			if (go) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (fire_tick) begin
				seg_s2 <= seg_nxt;
				dig_s2 <= digit_drive_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			tick_s2  <= tick_nxt;
			press_s2 <= press_rep;
			held_s2  <= held_rep;
			swap_s2  <= swap_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign segment_drive = seg_s2;
	assign digit_drive   = dig_s2;
	assign tick_second   = tick_s2.second;
	assign tick_half     = tick_s2.half;
	assign tick_quarter  = tick_s2.quarter;
	assign toggle_slow   = tick_s2.slow;
	assign toggle_fast   = tick_s2.fast;
	assign key_pressed   = press_s2;
	assign key_held      = held_s2;
	assign swap_pending  = swap_s2;

endmodule

### src/sskm_checker.sv
// Port-level checks of the display and key scan block, bound to the top level.
`include "seven_segment_scan_and_key_matrix_defines.svh"

module sskm_checker import sskm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SEG_W-1:0]  segment_drive,
	input logic [PINS-1:0]   digit_drive,
	input logic              tick_second,
	input logic              tick_half,
	input logic              tick_quarter
);

	// a stalled result stays put
	`SSKM_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(segment_drive) && $stable(digit_drive))
	// at most one digit selected at a time
	`SSKM_ASSERT_NOW(a_one_digit, out_valid, $onehot0(~digit_drive))
	// a wrap lands on count zero, which is a half and a quarter position
	`SSKM_ASSERT_NOW(a_wrap_ticks, out_valid && tick_second, tick_half && tick_quarter)
	// every half position is also a quarter position
	`SSKM_ASSERT_NOW(a_half_quarter, out_valid && tick_half, tick_quarter)

endmodule

bind seven_segment_scan_and_key_matrix sskm_checker u_sskm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.segment_drive (segment_drive),
	.digit_drive   (digit_drive),
	.tick_second   (tick_second),
	.tick_half     (tick_half),
	.tick_quarter  (tick_quarter)
);

### tb/seven_segment_scan_and_key_matrix_test.sv
// Self-checking testbench for the seven-segment scan and key matrix block.
module seven_segment_scan_and_key_matrix_test;
	import sskm_pkg::*;

	localparam int DIGITS = 4;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Power-on register values.
	localparam bit [8:0] PERIOD_AT_RESET = 9'd492;
	localparam bit [7:0] HOLD_AT_RESET   = 8'd50;

	// Character code to segment pattern, last entry shown for codes past the end.
	localparam int CHAR_LAST = 38;
	localparam bit [7:0] CHAR_SEGMENTS [0:CHAR_LAST] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h04, 8'h1E,
		8'h36, 8'h38, 8'h53, 8'h54, 8'h5C, 8'h73, 8'h53, 8'h50, 8'h6D, 8'h78,
		8'h3E, 8'h1C, 8'h53, 8'h53, 8'h6E, 8'h53, 8'h00, 8'h40, 8'h53
	};

	// Random phases: register settings, length and share of tick transactions.
	// Each new period tends to land below the count left by the phase before,
	// so the wrap from above the period gets exercised on the first tick.
	localparam int PHASES = 7;
	localparam int PHASE_PERIOD [PHASES] = '{492, 1, 511, 2, 130, 260, 77};
	localparam int PHASE_HOLD   [PHASES] = '{50, 1, 255, 3, 1, 7, 120};
	localparam int PHASE_ITEMS  [PHASES] = '{150, 200, 650, 200, 250, 300, 250};
	localparam int PHASE_TICKS  [PHASES] = '{60, 50, 90, 50, 60, 70, 55};
	localparam int JAM_PHASE = 2;
	localparam int CALM_TAIL = 100;

	// What the block shows after one transaction.
	typedef struct packed {
		logic [7:0] segments;
		logic [3:0] digits;
		logic       second;
		logic       half;
		logic       quarter;
		logic       slow;
		logic       fast;
		logic [3:0] pressed;
		logic [3:0] held;
		logic       swap;
	} panel_state_t;

	bit         clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [8:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] opcode;
	logic       key_sense;
	logic [2:0] digit;
	logic [7:0] value;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] segment_drive;
	logic [3:0] digit_drive;
	logic       tick_second;
	logic       tick_half;
	logic       tick_quarter;
	logic       toggle_slow;
	logic       toggle_fast;
	logic [3:0] key_pressed;
	logic [3:0] key_held;
	logic       swap_pending;

	// Idling controls shared between the stimulus and the receiver.
	bit gaps_on;
	bit stalls_on;
	bit jam_request;

	// Stimulus-side view of the keypad: keys held down and the next scan slot.
	bit [3:0]    keys_down;
	int unsigned key_slot;

	int unsigned cycle_count;

	// Scoreboard: mirrors the display and keypad state and queues what each
	// accepted transaction should produce.
	class panel_scoreboard;
		bit [8:0]     period_max;
		bit [7:0]     hold_reload;
		bit [8:0]     tick_count;
		int unsigned  scan_pos;
		bit [3:0]     keys_live;
		bit [3:0]     keys_prev;
		bit [7:0]     hold_count;
		bit [3:0]     press_flags;
		bit [3:0]     hold_flags;
		bit [7:0]     frame_bytes [2*DIGITS];
		bit           front_first;
		bit           swap_req;
		bit           slow_lvl;
		bit           fast_lvl;
		bit [7:0]     seg_pins;
		bit [3:0]     dig_pins;
		panel_state_t expected_q [$];
		int unsigned  mismatches;

		function new();
			period_max  = PERIOD_AT_RESET;
			hold_reload = HOLD_AT_RESET;
			tick_count  = '0;
			scan_pos    = 0;
			keys_live   = '0;
			keys_prev   = '0;
			hold_count  = '0;
			press_flags = '0;
			hold_flags  = '0;
			foreach (frame_bytes[i]) frame_bytes[i] = '0;
			front_first = 1'b1;
			swap_req    = 1'b0;
			slow_lvl    = 1'b0;
			fast_lvl    = 1'b0;
			seg_pins    = 8'hFF;
			dig_pins    = 4'hF;
			mismatches  = 0;
		endfunction

		function void set_register(reg_idx_t idx, bit [8:0] data);
			if (idx == REG_TICK_PERIOD_MAX) begin
				period_max = data;
			end else begin
				hold_reload = data[7:0];
			end
		endfunction

		function void note_input(item_t it);
			panel_state_t want;
			int unsigned  back;
			bit [3:0]     sel;
			want = '0;
			back = front_first ? DIGITS : 0;
			case (it.opcode)
			OP_TICK: begin
				if (tick_count < period_max) begin
					tick_count = tick_count + 9'd1;
				end else begin
					tick_count  = '0;
					want.second = 1'b1;
				end
				if (tick_count % 250 == 0) begin
					want.half = 1'b1;
					slow_lvl  = ~slow_lvl;
				end
				if (tick_count % 125 == 0) begin
					want.quarter = 1'b1;
					fast_lvl     = ~fast_lvl;
				end
				if (scan_pos >= DIGITS) scan_pos = 0;
				seg_pins = ~frame_bytes[(front_first ? 0 : DIGITS) + scan_pos];
				// only the first four positions have a select pin and a key bit
				if (scan_pos < 4) begin
					sel      = 4'b0001 << scan_pos;
					dig_pins = ~sel;
					if (!it.key_sense) begin
						keys_live = keys_live | sel;
					end else begin
						keys_live = keys_live & ~sel;
					end
				end else begin
					dig_pins = 4'hF;
				end
				scan_pos++;
				// frame end: new presses, hold repeat, then a pending swap
				if (scan_pos >= DIGITS) begin
					scan_pos    = 0;
					press_flags = press_flags | (keys_live & ~keys_prev);
					keys_prev   = keys_live;
					if (keys_live != 0) begin
						hold_count = hold_count - 8'd1;
						if (hold_count == 0) begin
							hold_count = hold_reload;
							hold_flags = hold_flags | keys_live;
						end
					end else begin
						hold_count = hold_reload;
					end
					if (swap_req) begin
						front_first = ~front_first;
						swap_req    = 1'b0;
					end
				end
			end
			OP_ASSIGN: begin
				if (it.digit < DIGITS) frame_bytes[back + it.digit] = it.value;
			end
			OP_OR: begin
				if (it.digit < DIGITS) frame_bytes[back + it.digit] |= it.value;
			end
			OP_AND: begin
				if (it.digit < DIGITS) frame_bytes[back + it.digit] &= it.value;
			end
			OP_CHAR: begin
				if (it.digit < DIGITS) begin
					frame_bytes[back + it.digit] =
						CHAR_SEGMENTS[(it.value > CHAR_LAST) ? CHAR_LAST : it.value];
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < DIGITS; i++) frame_bytes[back + i] = '0;
			end
			OP_SWAP: begin
				swap_req = 1'b1;
			end
			default: begin
			end
			endcase
			// a key read reports the flags as they stood, then clears them
			want.pressed = press_flags;
			want.held    = hold_flags;
			if (it.opcode == OP_READ) begin
				press_flags = '0;
				hold_flags  = '0;
			end
			want.segments = seg_pins;
			want.digits   = dig_pins;
			want.slow     = slow_lvl;
			want.fast     = fast_lvl;
			want.swap     = swap_req;
			expected_q.push_back(want);
		endfunction

		function void check_result(panel_state_t got);
			panel_state_t want;
			string        diffs;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("[%0t] unexpected transaction out: %p", $time, got);
				return;
			end
			want  = expected_q.pop_front();
			diffs = "";
			if (got.segments !== want.segments) diffs = {diffs, " segment_drive"};
			if (got.digits !== want.digits) diffs = {diffs, " digit_drive"};
			if (got.second !== want.second) diffs = {diffs, " tick_second"};
			if (got.half !== want.half) diffs = {diffs, " tick_half"};
			if (got.quarter !== want.quarter) diffs = {diffs, " tick_quarter"};
			if (got.slow !== want.slow) diffs = {diffs, " toggle_slow"};
			if (got.fast !== want.fast) diffs = {diffs, " toggle_fast"};
			if (got.pressed !== want.pressed) diffs = {diffs, " key_pressed"};
			if (got.held !== want.held) diffs = {diffs, " key_held"};
			if (got.swap !== want.swap) diffs = {diffs, " swap_pending"};
			if (diffs != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] mismatch on%s: expected %p, got %p", $time, diffs, want, got);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	panel_scoreboard sb;

	seven_segment_scan_and_key_matrix #(.DIGITS(DIGITS)) u_top (.*);

	// Clock, period of two units.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Watchdog: a run that stalls or loses a transaction ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Result monitor, sampled on the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result({segment_drive, digit_drive, tick_second, tick_half, tick_quarter,
				toggle_slow, toggle_fast, key_pressed, key_held, swap_pending});
		end
	end

	// Receiver: short random stalls, plus one long hold-off on request so the
	// pipeline fills and in_ready drops while the sender keeps offering.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (jam_request) begin
				jam_request = 1'b0;
				hold_left   = 64;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one transaction and hold it until accepted; an idle burst may come first.
	task automatic push_op(op_t op, bit sense, bit [2:0] dig, bit [7:0] val);
		item_t it;
		it.opcode    = op;
		it.key_sense = sense;
		it.digit     = dig;
		it.value     = val;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		key_sense <= sense;
		digit     <= dig;
		value     <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
		if (op == OP_TICK) key_slot = (key_slot + 1) % DIGITS;
	endtask

	// Drop valid and let everything in flight drain out.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, bit [8:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
	endtask

	// Half or more of the items are ticks, with keys held down over many frames, so
	// presses and hold repeats actually fire; a little sensing noise and all the write traffic.
	task automatic run_phase(int phase);
		int unsigned n;
		int unsigned pick;
		bit          sense;
		bit [2:0]    dig;
		bit [7:0]    val;
		for (n = 0; n < PHASE_ITEMS[phase]; n++) begin
			if (phase == PHASES - 1 && n == PHASE_ITEMS[phase] - CALM_TAIL) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			if (phase == JAM_PHASE && n == 100) jam_request = 1'b1;
			dig = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
			val = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < PHASE_TICKS[phase]) begin
				if (key_slot == 0 && $urandom_range(0, 29) == 0) keys_down = 4'($urandom_range(0, 15));
				if ($urandom_range(0, 11) == 0) begin
					sense = 1'($urandom_range(0, 1));
				end else begin
					sense = ~keys_down[key_slot];
				end
				push_op(OP_TICK, sense, dig, val);
			end else begin
				sense = 1'($urandom_range(0, 1));
				pick  = $urandom_range(0, 19);
				if (pick < 4) begin
					push_op(OP_ASSIGN, sense, dig, val);
				end else if (pick < 7) begin
					push_op(OP_OR, sense, dig, val);
				end else if (pick < 10) begin
					push_op(OP_AND, sense, dig, val);
				end else if (pick < 14) begin
					if ($urandom_range(0, 4) != 0) val = 8'($urandom_range(0, CHAR_LAST));
					push_op(OP_CHAR, sense, dig, val);
				end else if (pick < 15) begin
					push_op(OP_CLEAR, sense, dig, val);
				end else if (pick < 18) begin
					push_op(OP_SWAP, sense, dig, val);
				end else begin
					push_op(OP_READ, sense, dig, val);
				end
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_TICK_PERIOD_MAX;
		cfg_data    = '0;
		in_valid    = 1'b0;
		opcode      = OP_TICK;
		key_sense   = 1'b1;
		digit       = '0;
		value       = '0;
		gaps_on     = 1'b1;
		stalls_on   = 1'b1;
		jam_request = 1'b0;
		keys_down   = '0;
		key_slot    = 0;
		sb          = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: read straight after reset, writes at the byte extremes,
		// digits beyond the last pin, character codes at and past the table end,
		// a swap carried out at frame end, key presses, and a clear of the back
		// buffer once the swap has gone through.
		push_op(OP_READ, 1'b1, 3'd0, 8'h00);
		push_op(OP_ASSIGN, 1'b1, 3'd0, 8'hFF);
		push_op(OP_ASSIGN, 1'b1, 3'd3, 8'h00);
		push_op(OP_ASSIGN, 1'b0, 3'd4, 8'hAA);
		push_op(OP_ASSIGN, 1'b1, 3'd7, 8'h55);
		push_op(OP_OR, 1'b1, 3'd1, 8'h80);
		push_op(OP_AND, 1'b1, 3'd0, 8'h0F);
		push_op(OP_CHAR, 1'b1, 3'd1, 8'd0);
		push_op(OP_CHAR, 1'b1, 3'd2, 8'd38);
		push_op(OP_CHAR, 1'b1, 3'd3, 8'd39);
		push_op(OP_CHAR, 1'b1, 3'd0, 8'd255);
		push_op(OP_CHAR, 1'b1, 3'd5, 8'd3);
		push_op(OP_SWAP, 1'b0, 3'd0, 8'h00);
		for (int i = 0; i < 4; i++) push_op(OP_TICK, i[0], 3'(i), 8'h00);
		push_op(OP_READ, 1'b0, 3'd7, 8'hFF);
		for (int i = 0; i < 4; i++) push_op(OP_TICK, 1'b1, 3'd0, 8'h00);
		push_op(OP_CLEAR, 1'b1, 3'd6, 8'hFF);
		push_op(OP_OR, 1'b1, 3'd2, 8'hFF);
		push_op(OP_AND, 1'b1, 3'd2, 8'h00);
		push_op(OP_READ, 1'b1, 3'd0, 8'h00);

		// Random phases; registers change only once the block has drained.
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				write_register(REG_TICK_PERIOD_MAX, 9'(PHASE_PERIOD[p]));
				write_register(REG_HOLD_REPEAT, 9'(PHASE_HOLD[p]));
			end
			run_phase(p);
		end

		settle();
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
